/* rtl/dpcr_pkg.sv */
package dpcr_pkg;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_CONTACT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN    = 2'd2;

    localparam logic [31:0] CONTACT_RST = 32'd2621;
    localparam logic [30:0] THRESH_RST  = 31'd32768;
    localparam logic [15:0] GAIN_RST    = 16'd768;

    localparam logic [3:0] OP_NONE      = 4'd0;
    localparam logic [3:0] OP_SQX       = 4'd1;
    localparam logic [3:0] OP_SQY       = 4'd2;
    localparam logic [3:0] OP_SUMS      = 4'd3;
    localparam logic [3:0] OP_FAR       = 4'd4;
    localparam logic [3:0] OP_KEEP      = 4'd5;
    localparam logic [3:0] OP_NORM_INIT = 4'd6;
    localparam logic [3:0] OP_NORM_STEP = 4'd7;
    localparam logic [3:0] OP_SQRT_INIT = 4'd8;
    localparam logic [3:0] OP_SQRT_STEP = 4'd9;
    localparam logic [3:0] OP_DIV_INIT  = 4'd10;
    localparam logic [3:0] OP_DIV_STEP  = 4'd11;
    localparam logic [3:0] OP_NORMAL    = 4'd12;
    localparam logic [3:0] OP_MAC       = 4'd13;
    localparam logic [3:0] OP_BOUNCE    = 4'd14;
    localparam logic [3:0] OP_OUT       = 4'd15;

    localparam logic [5:0] ITER_LAST  = 6'd30;
    localparam logic [5:0] MS_SEP_END = 6'd2;
    localparam logic [5:0] MS_LAST    = 6'd38;

    localparam logic [1:0] MK_MULA = 2'd0;
    localparam logic [1:0] MK_MULB = 2'd1;
    localparam logic [1:0] MK_FIN  = 2'd2;

    localparam logic [3:0] A_DVX = 4'd0;
    localparam logic [3:0] A_DVY = 4'd1;
    localparam logic [3:0] A_VAX = 4'd2;
    localparam logic [3:0] A_VAY = 4'd3;
    localparam logic [3:0] A_VBX = 4'd4;
    localparam logic [3:0] A_VBY = 4'd5;
    localparam logic [3:0] A_VAN = 4'd6;
    localparam logic [3:0] A_VBN = 4'd7;
    localparam logic [3:0] A_VAT = 4'd8;
    localparam logic [3:0] A_VBT = 4'd9;
    localparam logic [3:0] A_T1  = 4'd10;

    localparam logic [1:0] B_NX   = 2'd0;
    localparam logic [1:0] B_NY   = 2'd1;
    localparam logic [1:0] B_NNY  = 2'd2;
    localparam logic [1:0] B_GAIN = 2'd3;

    localparam logic [1:0] FM_SINGLE = 2'd0;
    localparam logic [1:0] FM_ADD    = 2'd1;
    localparam logic [1:0] FM_SUB    = 2'd2;

    localparam logic [3:0] D_NONE = 4'd0;
    localparam logic [3:0] D_SEP  = 4'd1;
    localparam logic [3:0] D_VAN  = 4'd2;
    localparam logic [3:0] D_VBN  = 4'd3;
    localparam logic [3:0] D_VAT  = 4'd4;
    localparam logic [3:0] D_VBT  = 4'd5;
    localparam logic [3:0] D_T1   = 4'd6;
    localparam logic [3:0] D_G    = 4'd7;
    localparam logic [3:0] D_OAX  = 4'd8;
    localparam logic [3:0] D_OAY  = 4'd9;
    localparam logic [3:0] D_OBX  = 4'd10;
    localparam logic [3:0] D_OBY  = 4'd11;

    typedef struct packed {
        logic [3:0] op;
        logic [5:0] midx;
    } cmd_t;

    typedef struct packed {
        logic far;
        logic zero;
        logic t_ok;
        logic bounce;
    } status_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] a_sel;
        logic [1:0] b_sel;
        logic [1:0] fm;
        logic       sh8;
        logic [3:0] dest;
    } mstep_t;

    function automatic mstep_t mk(input logic [1:0] kind, input logic [3:0] a_sel,
                                  input logic [1:0] b_sel, input logic [1:0] fm,
                                  input logic sh8, input logic [3:0] dest);
        mstep_t r;
        r.kind  = kind;
        r.a_sel = a_sel;
        r.b_sel = b_sel;
        r.fm    = fm;
        r.sh8   = sh8;
        r.dest  = dest;
        return r;
    endfunction

    function automatic mstep_t mstep(input logic [5:0] idx);
        mstep_t r;
        case (idx)
            6'd0:  r = mk(MK_MULA, A_DVX, B_NX,   FM_SINGLE, 1'b0, D_NONE);
            6'd1:  r = mk(MK_MULB, A_DVY, B_NY,   FM_SINGLE, 1'b0, D_NONE);
            6'd2:  r = mk(MK_FIN,  A_DVX, B_NX,   FM_ADD,    1'b0, D_SEP);
            6'd3:  r = mk(MK_MULA, A_VAX, B_NX,   FM_SINGLE, 1'b0, D_NONE);
            6'd4:  r = mk(MK_MULB, A_VAY, B_NY,   FM_SINGLE, 1'b0, D_NONE);
            6'd5:  r = mk(MK_FIN,  A_VAX, B_NX,   FM_ADD,    1'b0, D_VAN);
            6'd6:  r = mk(MK_MULA, A_VBX, B_NX,   FM_SINGLE, 1'b0, D_NONE);
            6'd7:  r = mk(MK_MULB, A_VBY, B_NY,   FM_SINGLE, 1'b0, D_NONE);
            6'd8:  r = mk(MK_FIN,  A_VBX, B_NX,   FM_ADD,    1'b0, D_VBN);
            6'd9:  r = mk(MK_MULA, A_VAY, B_NX,   FM_SINGLE, 1'b0, D_NONE);
            6'd10: r = mk(MK_MULB, A_VAX, B_NY,   FM_SINGLE, 1'b0, D_NONE);
            6'd11: r = mk(MK_FIN,  A_VAX, B_NX,   FM_SUB,    1'b0, D_VAT);
            6'd12: r = mk(MK_MULA, A_VBY, B_NX,   FM_SINGLE, 1'b0, D_NONE);
            6'd13: r = mk(MK_MULB, A_VBX, B_NY,   FM_SINGLE, 1'b0, D_NONE);
            6'd14: r = mk(MK_FIN,  A_VBX, B_NX,   FM_SUB,    1'b0, D_VBT);
            6'd15: r = mk(MK_MULA, A_VBN, B_NX,   FM_SINGLE, 1'b0, D_NONE);
            6'd16: r = mk(MK_FIN,  A_VBN, B_NX,   FM_SINGLE, 1'b0, D_T1);
            6'd17: r = mk(MK_MULA, A_T1,  B_GAIN, FM_SINGLE, 1'b1, D_NONE);
            6'd18: r = mk(MK_FIN,  A_T1,  B_GAIN, FM_SINGLE, 1'b1, D_G);
            6'd19: r = mk(MK_MULA, A_VAT, B_NNY,  FM_SINGLE, 1'b0, D_NONE);
            6'd20: r = mk(MK_FIN,  A_VAT, B_NNY,  FM_SINGLE, 1'b0, D_OAX);
            6'd21: r = mk(MK_MULA, A_VBN, B_NY,   FM_SINGLE, 1'b0, D_NONE);
            6'd22: r = mk(MK_FIN,  A_VBN, B_NY,   FM_SINGLE, 1'b0, D_T1);
            6'd23: r = mk(MK_MULA, A_T1,  B_GAIN, FM_SINGLE, 1'b1, D_NONE);
            6'd24: r = mk(MK_FIN,  A_T1,  B_GAIN, FM_SINGLE, 1'b1, D_G);
            6'd25: r = mk(MK_MULA, A_VAT, B_NX,   FM_SINGLE, 1'b0, D_NONE);
            6'd26: r = mk(MK_FIN,  A_VAT, B_NX,   FM_SINGLE, 1'b0, D_OAY);
            6'd27: r = mk(MK_MULA, A_VAN, B_NX,   FM_SINGLE, 1'b0, D_NONE);
            6'd28: r = mk(MK_FIN,  A_VAN, B_NX,   FM_SINGLE, 1'b0, D_T1);
            6'd29: r = mk(MK_MULA, A_T1,  B_GAIN, FM_SINGLE, 1'b1, D_NONE);
            6'd30: r = mk(MK_FIN,  A_T1,  B_GAIN, FM_SINGLE, 1'b1, D_G);
            6'd31: r = mk(MK_MULA, A_VBT, B_NNY,  FM_SINGLE, 1'b0, D_NONE);
            6'd32: r = mk(MK_FIN,  A_VBT, B_NNY,  FM_SINGLE, 1'b0, D_OBX);
            6'd33: r = mk(MK_MULA, A_VAN, B_NY,   FM_SINGLE, 1'b0, D_NONE);
            6'd34: r = mk(MK_FIN,  A_VAN, B_NY,   FM_SINGLE, 1'b0, D_T1);
            6'd35: r = mk(MK_MULA, A_T1,  B_GAIN, FM_SINGLE, 1'b1, D_NONE);
            6'd36: r = mk(MK_FIN,  A_T1,  B_GAIN, FM_SINGLE, 1'b1, D_G);
            6'd37: r = mk(MK_MULA, A_VBT, B_NX,   FM_SINGLE, 1'b0, D_NONE);
            6'd38: r = mk(MK_FIN,  A_VBT, B_NX,   FM_SINGLE, 1'b0, D_OBY);
            default: r = mk(MK_MULA, A_DVX, B_NX, FM_SINGLE, 1'b0, D_NONE);
        endcase
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [43:0] v);
        if (v > 44'sd2147483647)
            return 32'sh7FFFFFFF;
        else if (v < -44'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

endpackage

/* rtl/disc_pair_collision_response.sv */
// Disc pair collision response.
// Input channel s_axis_*: one item holds the centres and velocities of two
// equal-mass discs, signed fixed point with FRAC_BITS fraction bits.
// Output channel m_axis_*: one item per input item with the new velocities,
// the stored separation speed and the bounce and collision flags.
// Configuration channel cfg_*: writes contact distance squared (index 0),
// approach threshold (index 1) and bounce gain (index 2); always ready.
// One item is worked on at a time by a controller and a datapath built
// around one shared multiplier, a bit-serial square root and a pair of
// bit-serial dividers. With no contact or with coincident centres the item
// goes to the output after the distance check. On contact, up to 30 two-bit
// normalisation steps come before the 31-step square root and the 31-step
// divide; then the separation speed is formed, and only a bounce goes on to
// the new velocities. A new item is accepted once the previous one has moved
// to the output register, even while that result still waits; a stalled
// receiver holds the result and blocks only the following one. Reset
// restores the register defaults and clears the collision flag and stored
// separation.
module disc_pair_collision_response
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // pos_a_x, pos_a_y, pos_b_x, pos_b_y, vel_a_x, vel_a_y, vel_b_x, vel_b_y
    input  logic [255:0]                       s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // new_vel_a_x, new_vel_a_y, new_vel_b_x, new_vel_b_y, closing_speed
    output logic [159:0]                       m_axis_tdata,
    // velocities_changed, collision_flag
    output logic [1:0]                         m_axis_tuser,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [dpcr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [31:0]                        cfg_data
);

    dpcr_pkg::cmd_t    cmd;
    dpcr_pkg::status_t st;
    logic              in_fire;
    logic signed [31:0] nvax, nvay, nvbx, nvby, csp;
    logic              vchg, cflag;

    assign cfg_ready = 1'b1;
    assign in_fire   = s_axis_tvalid && s_axis_tready;

    dpcr_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .st        (st),
        .cmd       (cmd)
    );

    dpcr_dp #(.FRAC_BITS(FRAC_BITS)) u_dp
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_valid && cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .load               (in_fire),
        .pos_a_x            (s_axis_tdata[31:0]),
        .pos_a_y            (s_axis_tdata[63:32]),
        .pos_b_x            (s_axis_tdata[95:64]),
        .pos_b_y            (s_axis_tdata[127:96]),
        .vel_a_x            (s_axis_tdata[159:128]),
        .vel_a_y            (s_axis_tdata[191:160]),
        .vel_b_x            (s_axis_tdata[223:192]),
        .vel_b_y            (s_axis_tdata[255:224]),
        .cmd                (cmd),
        .st                 (st),
        .new_vel_a_x        (nvax),
        .new_vel_a_y        (nvay),
        .new_vel_b_x        (nvbx),
        .new_vel_b_y        (nvby),
        .velocities_changed (vchg),
        .collision_flag     (cflag),
        .closing_speed      (csp)
    );

    assign m_axis_tdata = {csp, nvby, nvbx, nvay, nvax};
    assign m_axis_tuser = {cflag, vchg};

endmodule

/* rtl/dpcr_ctrl.sv */
module dpcr_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  dpcr_pkg::status_t st,
    output dpcr_pkg::cmd_t    cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SQX   = 4'd1;
    localparam logic [3:0] S_SQY   = 4'd2;
    localparam logic [3:0] S_SUMS  = 4'd3;
    localparam logic [3:0] S_CHECK = 4'd4;
    localparam logic [3:0] S_NORM  = 4'd5;
    localparam logic [3:0] S_SQRT  = 4'd6;
    localparam logic [3:0] S_DIVI  = 4'd7;
    localparam logic [3:0] S_DIV   = 4'd8;
    localparam logic [3:0] S_NRML  = 4'd9;
    localparam logic [3:0] S_MAC   = 4'd10;
    localparam logic [3:0] S_TEST  = 4'd11;
    localparam logic [3:0] S_BNC   = 4'd12;
    localparam logic [3:0] S_OUT   = 4'd13;

    logic [3:0] state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;
    logic       out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd.op         = dpcr_pkg::OP_NONE;
        cmd.midx       = cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_SQX;
            end
            S_SQX:
            begin
                cmd.op     = dpcr_pkg::OP_SQX;
                state_next = S_SQY;
            end
            S_SQY:
            begin
                cmd.op     = dpcr_pkg::OP_SQY;
                state_next = S_SUMS;
            end
            S_SUMS:
            begin
                cmd.op     = dpcr_pkg::OP_SUMS;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (st.far)
                begin
                    cmd.op     = dpcr_pkg::OP_FAR;
                    state_next = S_OUT;
                end
                else if (st.zero)
                begin
                    cmd.op     = dpcr_pkg::OP_KEEP;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.op     = dpcr_pkg::OP_NORM_INIT;
                    state_next = S_NORM;
                end
            end
            S_NORM:
            begin
                if (st.t_ok)
                begin
                    cmd.op     = dpcr_pkg::OP_SQRT_INIT;
                    cnt_next   = '0;
                    state_next = S_SQRT;
                end
                else
                    cmd.op = dpcr_pkg::OP_NORM_STEP;
            end
            S_SQRT:
            begin
                cmd.op   = dpcr_pkg::OP_SQRT_STEP;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == dpcr_pkg::ITER_LAST)
                    state_next = S_DIVI;
            end
            S_DIVI:
            begin
                cmd.op     = dpcr_pkg::OP_DIV_INIT;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.op   = dpcr_pkg::OP_DIV_STEP;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == dpcr_pkg::ITER_LAST)
                    state_next = S_NRML;
            end
            S_NRML:
            begin
                cmd.op     = dpcr_pkg::OP_NORMAL;
                cnt_next   = '0;
                state_next = S_MAC;
            end
            S_MAC:
            begin
                cmd.op   = dpcr_pkg::OP_MAC;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == dpcr_pkg::MS_SEP_END)
                    state_next = S_TEST;
                else if (cnt_reg == dpcr_pkg::MS_LAST)
                    state_next = S_BNC;
            end
            S_TEST:
            begin
                if (st.bounce)
                    state_next = S_MAC;
                else
                begin
                    cmd.op     = dpcr_pkg::OP_KEEP;
                    state_next = S_OUT;
                end
            end
            S_BNC:
            begin
                cmd.op     = dpcr_pkg::OP_BOUNCE;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op         = dpcr_pkg::OP_OUT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

/* rtl/dpcr_dp.sv */
module dpcr_dp
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [dpcr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [31:0]                         cfg_data,
    input  logic                                load,
    input  logic signed [31:0]                  pos_a_x,
    input  logic signed [31:0]                  pos_a_y,
    input  logic signed [31:0]                  pos_b_x,
    input  logic signed [31:0]                  pos_b_y,
    input  logic signed [31:0]                  vel_a_x,
    input  logic signed [31:0]                  vel_a_y,
    input  logic signed [31:0]                  vel_b_x,
    input  logic signed [31:0]                  vel_b_y,
    input  dpcr_pkg::cmd_t                      cmd,
    output dpcr_pkg::status_t                   st,
    output logic signed [31:0]                  new_vel_a_x,
    output logic signed [31:0]                  new_vel_a_y,
    output logic signed [31:0]                  new_vel_b_x,
    output logic signed [31:0]                  new_vel_b_y,
    output logic                                velocities_changed,
    output logic                                collision_flag,
    output logic signed [31:0]                  closing_speed
);

    localparam int BIG_BITS = (32 + FRAC_BITS + 1) / 2;
    localparam int LIM_W    = 32 + FRAC_BITS;

    logic [31:0] contact_reg;
    logic [30:0] thresh_reg;
    logic [15:0] gain_reg;

    logic signed [31:0] vax_reg, vay_reg, vbx_reg, vby_reg;
    logic signed [32:0] dvx_reg, dvy_reg;
    logic               dxneg_reg, dyneg_reg, big_reg;
    logic [30:0]        ux_reg, uy_reg;
    logic signed [65:0] prod_reg, acc_reg;
    logic [61:0]        t_reg;
    logic [34:0]        srem_reg;
    logic [30:0]        root_reg;
    logic [31:0]        remx_reg, remy_reg;
    logic [30:0]        nsx_reg, nsy_reg, qx_reg, qy_reg;
    logic signed [31:0] nx_reg, ny_reg;
    logic signed [33:0] van_reg, vbn_reg, vat_reg, vbt_reg, t1_reg;
    logic signed [35:0] sep_reg;
    logic signed [41:0] g_reg;
    logic signed [31:0] wax_reg, way_reg, wbx_reg, wby_reg;
    logic               chg_reg;
    logic               collided_reg;
    logic signed [31:0] last_sep_reg;

    logic signed [31:0] o_vax_reg, o_vay_reg, o_vbx_reg, o_vby_reg, o_sep_reg;
    logic               o_chg_reg, o_col_reg;

    logic signed [32:0] dx, dy;
    logic [32:0]        adx, ady;
    logic signed [33:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [65:0] mul_p;
    logic signed [31:0] nny;
    dpcr_pkg::mstep_t   ms;
    logic signed [65:0] fsum, fsh;
    logic signed [43:0] osum;
    logic [34:0]        sr2, strial;
    logic [31:0]        dr2x, dr2y, mden;
    logic [65:0]        lim;
    logic signed [36:0] bsum;

    assign dx  = {pos_b_x[31], pos_b_x} - {pos_a_x[31], pos_a_x};
    assign dy  = {pos_b_y[31], pos_b_y} - {pos_a_y[31], pos_a_y};
    assign adx = dx[32] ? -dx : dx;
    assign ady = dy[32] ? -dy : dy;
    assign nny = -ny_reg;
    assign ms  = dpcr_pkg::mstep(cmd.midx);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (cmd.op == dpcr_pkg::OP_SQX)
        begin
            mul_a = {3'b000, ux_reg};
            mul_b = {1'b0, ux_reg};
        end
        else if (cmd.op == dpcr_pkg::OP_SQY || cmd.op == dpcr_pkg::OP_SUMS)
        begin
            mul_a = {3'b000, uy_reg};
            mul_b = {1'b0, uy_reg};
        end
        else
        begin
            case (ms.a_sel)
                dpcr_pkg::A_DVX: mul_a = {dvx_reg[32], dvx_reg};
                dpcr_pkg::A_DVY: mul_a = {dvy_reg[32], dvy_reg};
                dpcr_pkg::A_VAX: mul_a = {{2{vax_reg[31]}}, vax_reg};
                dpcr_pkg::A_VAY: mul_a = {{2{vay_reg[31]}}, vay_reg};
                dpcr_pkg::A_VBX: mul_a = {{2{vbx_reg[31]}}, vbx_reg};
                dpcr_pkg::A_VBY: mul_a = {{2{vby_reg[31]}}, vby_reg};
                dpcr_pkg::A_VAN: mul_a = van_reg;
                dpcr_pkg::A_VBN: mul_a = vbn_reg;
                dpcr_pkg::A_VAT: mul_a = vat_reg;
                dpcr_pkg::A_VBT: mul_a = vbt_reg;
                dpcr_pkg::A_T1:  mul_a = t1_reg;
                default:         mul_a = '0;
            endcase
            case (ms.b_sel)
                dpcr_pkg::B_NX:   mul_b = nx_reg;
                dpcr_pkg::B_NY:   mul_b = ny_reg;
                dpcr_pkg::B_NNY:  mul_b = nny;
                dpcr_pkg::B_GAIN: mul_b = {16'd0, gain_reg};
                default:          mul_b = '0;
            endcase
        end
    end

    assign mul_p = mul_a * mul_b;

    always_comb
    begin
        case (ms.fm)
            dpcr_pkg::FM_ADD: fsum = acc_reg + prod_reg;
            dpcr_pkg::FM_SUB: fsum = acc_reg - prod_reg;
            default:          fsum = prod_reg;
        endcase
        fsh  = ms.sh8 ? (fsum >>> 8) : (fsum >>> 30);
        osum = {{2{g_reg[41]}}, g_reg} + {{10{fsh[33]}}, fsh[33:0]};
    end

    assign sr2    = {srem_reg[32:0], t_reg[61:60]};
    assign strial = {2'b00, root_reg, 2'b01};
    assign mden   = {1'b0, root_reg};
    assign dr2x   = {remx_reg[30:0], nsx_reg[30]};
    assign dr2y   = {remy_reg[30:0], nsy_reg[30]};
    assign lim    = {{(66-LIM_W){1'b0}}, contact_reg, {FRAC_BITS{1'b0}}};
    assign bsum   = {sep_reg[35], sep_reg} + {6'd0, thresh_reg};

    assign st.far    = big_reg || !(acc_reg < $signed(lim));
    assign st.zero   = (acc_reg == '0);
    assign st.t_ok   = t_reg[61] | t_reg[60];
    assign st.bounce = (bsum <= 37'sd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            contact_reg  <= dpcr_pkg::CONTACT_RST;
            thresh_reg   <= dpcr_pkg::THRESH_RST;
            gain_reg     <= dpcr_pkg::GAIN_RST;
            collided_reg <= 1'b0;
            last_sep_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    dpcr_pkg::CFG_CONTACT: contact_reg <= cfg_data;
                    dpcr_pkg::CFG_THRESH:  thresh_reg  <= cfg_data[30:0];
                    dpcr_pkg::CFG_GAIN:    gain_reg    <= cfg_data[15:0];
                    default:               ;
                endcase
            end
            if (cmd.op == dpcr_pkg::OP_FAR)
                collided_reg <= 1'b0;
            if (cmd.op == dpcr_pkg::OP_MAC && ms.kind == dpcr_pkg::MK_FIN
                && ms.dest == dpcr_pkg::D_SEP)
            begin
                collided_reg <= fsh[65];
                last_sep_reg <= dpcr_pkg::sat32({{8{fsh[35]}}, fsh[35:0]});
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            vax_reg   <= vel_a_x;
            vay_reg   <= vel_a_y;
            vbx_reg   <= vel_b_x;
            vby_reg   <= vel_b_y;
            dvx_reg   <= {vel_b_x[31], vel_b_x} - {vel_a_x[31], vel_a_x};
            dvy_reg   <= {vel_b_y[31], vel_b_y} - {vel_a_y[31], vel_a_y};
            dxneg_reg <= dx[32];
            dyneg_reg <= dy[32];
            big_reg   <= (adx[31:BIG_BITS] != '0) || (ady[31:BIG_BITS] != '0);
            ux_reg    <= adx[30:0];
            uy_reg    <= ady[30:0];
        end
        case (cmd.op)
            dpcr_pkg::OP_SQX:
                prod_reg <= mul_p;
            dpcr_pkg::OP_SQY:
            begin
                acc_reg  <= prod_reg;
                prod_reg <= mul_p;
            end
            dpcr_pkg::OP_SUMS:
                acc_reg <= acc_reg + prod_reg;
            dpcr_pkg::OP_FAR, dpcr_pkg::OP_KEEP:
                chg_reg <= 1'b0;
            dpcr_pkg::OP_NORM_INIT:
                t_reg <= acc_reg[61:0];
            dpcr_pkg::OP_NORM_STEP:
            begin
                t_reg  <= {t_reg[59:0], 2'b00};
                ux_reg <= {ux_reg[29:0], 1'b0};
                uy_reg <= {uy_reg[29:0], 1'b0};
            end
            dpcr_pkg::OP_SQRT_INIT:
            begin
                srem_reg <= '0;
                root_reg <= '0;
            end
            dpcr_pkg::OP_SQRT_STEP:
            begin
                t_reg <= {t_reg[59:0], 2'b00};
                if (sr2 >= strial)
                begin
                    srem_reg <= sr2 - strial;
                    root_reg <= {root_reg[29:0], 1'b1};
                end
                else
                begin
                    srem_reg <= sr2;
                    root_reg <= {root_reg[29:0], 1'b0};
                end
            end
            dpcr_pkg::OP_DIV_INIT:
            begin
                remx_reg <= {2'b00, ux_reg[30:1]};
                remy_reg <= {2'b00, uy_reg[30:1]};
                nsx_reg  <= {ux_reg[0], 30'd0};
                nsy_reg  <= {uy_reg[0], 30'd0};
            end
            dpcr_pkg::OP_DIV_STEP:
            begin
                nsx_reg <= {nsx_reg[29:0], 1'b0};
                nsy_reg <= {nsy_reg[29:0], 1'b0};
                if (dr2x >= mden)
                begin
                    remx_reg <= dr2x - mden;
                    qx_reg   <= {qx_reg[29:0], 1'b1};
                end
                else
                begin
                    remx_reg <= dr2x;
                    qx_reg   <= {qx_reg[29:0], 1'b0};
                end
                if (dr2y >= mden)
                begin
                    remy_reg <= dr2y - mden;
                    qy_reg   <= {qy_reg[29:0], 1'b1};
                end
                else
                begin
                    remy_reg <= dr2y;
                    qy_reg   <= {qy_reg[29:0], 1'b0};
                end
            end
            dpcr_pkg::OP_NORMAL:
            begin
                nx_reg <= dxneg_reg ? -$signed({1'b0, qx_reg}) : $signed({1'b0, qx_reg});
                ny_reg <= dyneg_reg ? -$signed({1'b0, qy_reg}) : $signed({1'b0, qy_reg});
            end
            dpcr_pkg::OP_MAC:
            begin
                case (ms.kind)
                    dpcr_pkg::MK_MULA:
                        prod_reg <= mul_p;
                    dpcr_pkg::MK_MULB:
                    begin
                        acc_reg  <= prod_reg;
                        prod_reg <= mul_p;
                    end
                    default:
                    begin
                        case (ms.dest)
                            dpcr_pkg::D_SEP: sep_reg <= fsh[35:0];
                            dpcr_pkg::D_VAN: van_reg <= fsh[33:0];
                            dpcr_pkg::D_VBN: vbn_reg <= fsh[33:0];
                            dpcr_pkg::D_VAT: vat_reg <= fsh[33:0];
                            dpcr_pkg::D_VBT: vbt_reg <= fsh[33:0];
                            dpcr_pkg::D_T1:  t1_reg  <= fsh[33:0];
                            dpcr_pkg::D_G:   g_reg   <= fsh[41:0];
                            dpcr_pkg::D_OAX: wax_reg <= dpcr_pkg::sat32(osum);
                            dpcr_pkg::D_OAY: way_reg <= dpcr_pkg::sat32(osum);
                            dpcr_pkg::D_OBX: wbx_reg <= dpcr_pkg::sat32(osum);
                            dpcr_pkg::D_OBY: wby_reg <= dpcr_pkg::sat32(osum);
                            default:         ;
                        endcase
                    end
                endcase
            end
            dpcr_pkg::OP_BOUNCE:
                chg_reg <= 1'b1;
            dpcr_pkg::OP_OUT:
            begin
                o_vax_reg <= chg_reg ? wax_reg : vax_reg;
                o_vay_reg <= chg_reg ? way_reg : vay_reg;
                o_vbx_reg <= chg_reg ? wbx_reg : vbx_reg;
                o_vby_reg <= chg_reg ? wby_reg : vby_reg;
                o_chg_reg <= chg_reg;
                o_col_reg <= collided_reg;
                o_sep_reg <= last_sep_reg;
            end
            default:
                ;
        endcase
    end

    assign new_vel_a_x        = o_vax_reg;
    assign new_vel_a_y        = o_vay_reg;
    assign new_vel_b_x        = o_vbx_reg;
    assign new_vel_b_y        = o_vby_reg;
    assign velocities_changed = o_chg_reg;
    assign collision_flag     = o_col_reg;
    assign closing_speed      = o_sep_reg;

endmodule
